// ===== hw/rtl/lcrts_pkg.sv =====
// Shared constants, codes and types for the load-cell readout with tare and scaling.
`default_nettype none

package lcrts_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_SAMPLES = 63;
	localparam int FRAC_BITS   = 16;

	localparam int HP_W     = 8;
	localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
	localparam int PULSE_W  = $clog2(SAMPLE_BITS + 1);
	localparam int SUM_W    = SAMPLE_BITS + CNT_W;
	localparam int CPK_W    = 24;
	localparam int WEIGHT_W = 41;
	localparam int CFG_W    = 24;
	localparam int IDX_W    = 2;

	// serial divider: dividend wide enough for |diff| << FRAC_BITS and for |sum|
	localparam int DIV_W    = WEIGHT_W;
	localparam int DVSR_W   = CPK_W;
	localparam int DSTEP_W  = $clog2(DIV_W + 1);

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_TARE  = 2'd1;
	localparam logic [1:0] KIND_WEIGH = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [IDX_W-1:0] REG_TARE_N      = 2'd1;
	localparam logic [IDX_W-1:0] REG_WEIGH_N     = 2'd2;
	localparam logic [IDX_W-1:0] REG_COUNTS_KG   = 2'd3;

	localparam logic [HP_W-1:0]  HP_RESET      = 8'd1;
	localparam logic [CNT_W-1:0] TARE_N_RESET  = 6'd20;
	localparam logic [CNT_W-1:0] WEIGH_N_RESET = 6'd10;
	localparam logic [CPK_W-1:0] CPK_RESET     = 24'd91760;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_WAIT,
		RD_HIGH,
		RD_LOW
	} rd_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_AVG,
		ST_WEIGH,
		ST_OUT
	} ctl_state_t;

	typedef struct packed {
		logic                    clock_level;
		logic                    busy;
		logic                    done;
		logic                    is_tare;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        run_len;
	} rd_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcrts_readout.sv =====
// Serial converter readout sequencer: clock generation, bit capture and sample summing.
`default_nettype none

module lcrts_readout (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [1:0]                     kind,
	input  wire logic                           data_level,
	input  wire logic [lcrts_pkg::HP_W-1:0]     half_period,
	input  wire logic [lcrts_pkg::CNT_W-1:0]    tare_n,
	input  wire logic [lcrts_pkg::CNT_W-1:0]    weigh_n,
	output lcrts_pkg::rd_stat_t                 stat
);

	lcrts_pkg::rd_phase_t phase_q, phase_d;

	logic [lcrts_pkg::HP_W-1:0]        hpc_q, hpc_d;
	logic [lcrts_pkg::PULSE_W-1:0]     pulse_q, pulse_d;
	logic [lcrts_pkg::SAMPLE_BITS-1:0] shift_q, shift_d;
	logic [lcrts_pkg::CNT_W-1:0]       sc_q, sc_d;
	logic signed [lcrts_pkg::SUM_W-1:0] sum_q, sum_d;
	logic                              tare_q, tare_d;
	logic                              clk_q, clk_d;
	logic                              done_q, done_d;
	logic [lcrts_pkg::CNT_W-1:0]       runlen_q;

	logic [lcrts_pkg::HP_W-1:0]   hp;
	logic [lcrts_pkg::HP_W:0]     cnt_inc;
	logic                         tick, start, hit, last_pulse, run_end;
	logic [lcrts_pkg::CNT_W-1:0]  n_raw, run_len, sc_inc;
	logic signed [lcrts_pkg::SUM_W-1:0] sample_sext;

	always_comb begin
		hp          = (half_period == '0) ? lcrts_pkg::HP_W'(1) : half_period;
		cnt_inc     = {1'b0, hpc_q} + (lcrts_pkg::HP_W + 1)'(1);
		hit         = cnt_inc >= {1'b0, hp};
		tick        = step && (kind == lcrts_pkg::KIND_TICK);
		start       = step && ((kind == lcrts_pkg::KIND_TARE) ||
			(kind == lcrts_pkg::KIND_WEIGH));
		last_pulse  = pulse_q >= lcrts_pkg::PULSE_W'(lcrts_pkg::SAMPLE_BITS);
		n_raw       = tare_q ? tare_n : weigh_n;
		// a count of zero runs one conversion
		run_len     = (n_raw == '0) ? lcrts_pkg::CNT_W'(1) : n_raw;
		sc_inc      = sc_q + lcrts_pkg::CNT_W'(1);
		run_end     = sc_inc >= run_len;
		sample_sext = lcrts_pkg::SUM_W'(signed'(shift_q));
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			lcrts_pkg::RD_IDLE: begin
				if (start) phase_d = lcrts_pkg::RD_WAIT;
			end
			lcrts_pkg::RD_WAIT: begin
				if (tick && !data_level) phase_d = lcrts_pkg::RD_HIGH;
			end
			lcrts_pkg::RD_HIGH: begin
				if (tick && hit) phase_d = lcrts_pkg::RD_LOW;
			end
			lcrts_pkg::RD_LOW: begin
				if (tick && hit) begin
					if (!last_pulse)
						phase_d = lcrts_pkg::RD_HIGH;
					else if (run_end)
						phase_d = lcrts_pkg::RD_IDLE;
					else
						phase_d = lcrts_pkg::RD_WAIT;
				end
			end
			default: phase_d = lcrts_pkg::RD_IDLE;
		endcase
	end

	// datapath updates per phase
	always_comb begin
		hpc_d   = hpc_q;
		pulse_d = pulse_q;
		shift_d = shift_q;
		sc_d    = sc_q;
		sum_d   = sum_q;
		tare_d  = tare_q;
		clk_d   = clk_q;
		done_d  = 1'b0;
		case (phase_q)
			lcrts_pkg::RD_IDLE: begin
				if (start) begin
					tare_d  = (kind == lcrts_pkg::KIND_TARE);
					sc_d    = '0;
					sum_d   = '0;
					pulse_d = '0;
					hpc_d   = '0;
					shift_d = '0;
					clk_d   = 1'b0;
				end
			end
			lcrts_pkg::RD_WAIT: begin
				if (tick && !data_level) begin
					clk_d   = 1'b1;
					hpc_d   = '0;
					pulse_d = '0;
					shift_d = '0;
				end
			end
			lcrts_pkg::RD_HIGH: begin
				if (tick) begin
					hpc_d = cnt_inc[lcrts_pkg::HP_W-1:0];
					if (hit) begin
						// sample on data pulses only, not on the gain pulse
						if (!last_pulse)
							shift_d = {shift_q[lcrts_pkg::SAMPLE_BITS-2:0], data_level};
						clk_d = 1'b0;
						hpc_d = '0;
					end
				end
			end
			lcrts_pkg::RD_LOW: begin
				if (tick) begin
					hpc_d = cnt_inc[lcrts_pkg::HP_W-1:0];
					if (hit) begin
						hpc_d = '0;
						if (last_pulse) begin
							sum_d   = sum_q + sample_sext;
							sc_d    = sc_inc;
							pulse_d = '0;
							done_d  = run_end;
						end else begin
							pulse_d = pulse_q + lcrts_pkg::PULSE_W'(1);
							clk_d   = 1'b1;
						end
					end
				end
			end
			default: begin
				clk_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lcrts_pkg::RD_IDLE;
			hpc_q    <= '0;
			pulse_q  <= '0;
			shift_q  <= '0;
			sc_q     <= '0;
			sum_q    <= '0;
			tare_q   <= 1'b0;
			clk_q    <= 1'b0;
			done_q   <= 1'b0;
			runlen_q <= '0;
		end else begin
			phase_q <= phase_d;
			hpc_q   <= hpc_d;
			pulse_q <= pulse_d;
			shift_q <= shift_d;
			sc_q    <= sc_d;
			sum_q   <= sum_d;
			tare_q  <= tare_d;
			clk_q   <= clk_d;
			done_q  <= done_d;
			if (done_d) runlen_q <= run_len;
		end
	end

	assign stat.clock_level = clk_q;
	assign stat.busy        = (phase_q != lcrts_pkg::RD_IDLE);
	assign stat.done        = done_q;
	assign stat.is_tare     = tare_q;
	assign stat.sum         = sum_q;
	assign stat.run_len     = runlen_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q == lcrts_pkg::RD_IDLE))
		else $error("run finished but readout not idle");

endmodule

`default_nettype wire

// ===== hw/rtl/lcrts_divider.sv =====
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none

module lcrts_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lcrts_pkg::DIV_W-1:0]   dividend,
	input  wire logic [lcrts_pkg::DVSR_W-1:0]  divisor,
	output lcrts_pkg::div_stat_t               stat,
	output logic      [lcrts_pkg::DIV_W-1:0]   quotient
);

	logic [lcrts_pkg::DIV_W-1:0]   quot_q;
	logic [lcrts_pkg::DVSR_W-1:0]  rem_q;
	logic [lcrts_pkg::DVSR_W-1:0]  dvsr_q;
	logic [lcrts_pkg::DSTEP_W-1:0] step_q;
	logic                          busy_q, done_q;

	logic [lcrts_pkg::DVSR_W+1:0]  trial;
	logic                          ge, last;

	always_comb begin
		trial = {1'b0, rem_q, quot_q[lcrts_pkg::DIV_W-1]} - {2'b00, dvsr_q};
		ge    = !trial[lcrts_pkg::DVSR_W+1];
		last  = step_q == lcrts_pkg::DSTEP_W'(lcrts_pkg::DIV_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quot_q <= '0;
			rem_q  <= '0;
			dvsr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				quot_q <= dividend;
				rem_q  <= '0;
				dvsr_q <= divisor;
			end else if (busy_q) begin
				// shift the next dividend bit into the remainder, keep it if it fits
				quot_q <= {quot_q[lcrts_pkg::DIV_W-2:0], ge};
				rem_q  <= ge ? trial[lcrts_pkg::DVSR_W-1:0]
					: {rem_q[lcrts_pkg::DVSR_W-2:0], quot_q[lcrts_pkg::DIV_W-1]};
				step_q <= step_q + lcrts_pkg::DSTEP_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;

	a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !$past(start)) |-> (rem_q < dvsr_q))
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== hw/rtl/load_cell_readout_tare_scale.sv =====
// Load-cell converter readout with tare offset and Q16 kilogram scaling: top level.
// Each input beat is a tick (with the data line level), a start command or a reserved
// kind, and it yields exactly one output beat. A beat that does not finish a run goes
// through the evaluation and output states into the output register. The beat that
// ends the last conversion of a run goes through the shared serial divider, which
// produces one quotient bit per cycle: the average (sum / N) costs one pass, which is
// all a tare needs, and a weigh adds a second pass for (average - offset) * 2^16 /
// counts_per_kg. The input is not ready while a beat is in work; it is ready again
// while the output beat still waits to be taken. Configuration writes take effect at
// once and should be made while the block is idle.
`default_nettype none

module load_cell_readout_tare_scale (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] data_level, [7:1] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [0] clock_level, [1] busy_res,
	                                    // [25:2] average_counts, [66:26] weight_q16,
	                                    // [71:67] zero
	output logic [1:0]       m_tuser,   // [0] result_valid, [1] result_is_tare
	input  wire logic        cfg_we,
	input  wire logic [lcrts_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [lcrts_pkg::CFG_W-1:0] cfg_data
);

	localparam int SB = lcrts_pkg::SAMPLE_BITS;
	localparam int WW = lcrts_pkg::WEIGHT_W;

	// configuration
	logic [lcrts_pkg::HP_W-1:0]  half_period_q;
	logic [lcrts_pkg::CNT_W-1:0] tare_n_q, weigh_n_q;
	logic [lcrts_pkg::CPK_W-1:0] cpk_q;

	lcrts_pkg::ctl_state_t st_q, st_d;
	lcrts_pkg::rd_stat_t   rd;
	lcrts_pkg::div_stat_t  div_stat;

	logic                        accept, out_free;
	logic                        div_start;
	logic [lcrts_pkg::DIV_W-1:0] div_dividend, div_quot;
	logic [lcrts_pkg::DVSR_W-1:0] div_divisor;

	logic signed [SB-1:0]   offset_q;
	logic                   res_valid_q, res_tare_q, diff_neg_q;
	logic signed [SB-1:0]   res_avg_q;
	logic signed [WW-1:0]   res_weight_q;

	logic                   m_tvalid_q, m_clock_q, m_busy_q, m_valid_q, m_tare_q;
	logic signed [SB-1:0]   m_avg_q;
	logic signed [WW-1:0]   m_weight_q;

	logic [lcrts_pkg::SUM_W-1:0] sum_mag;
	logic signed [SB-1:0]   avg;
	logic signed [SB:0]     diff;
	logic [SB:0]            diff_mag;
	logic signed [WW-1:0]   weight;
	logic [lcrts_pkg::CPK_W-1:0] cpk_eff;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= lcrts_pkg::HP_RESET;
			tare_n_q      <= lcrts_pkg::TARE_N_RESET;
			weigh_n_q     <= lcrts_pkg::WEIGH_N_RESET;
			cpk_q         <= lcrts_pkg::CPK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lcrts_pkg::REG_HALF_PERIOD: half_period_q <= cfg_data[lcrts_pkg::HP_W-1:0];
				lcrts_pkg::REG_TARE_N:      tare_n_q  <= cfg_data[lcrts_pkg::CNT_W-1:0];
				lcrts_pkg::REG_WEIGH_N:     weigh_n_q <= cfg_data[lcrts_pkg::CNT_W-1:0];
				lcrts_pkg::REG_COUNTS_KG:   cpk_q     <= cfg_data[lcrts_pkg::CPK_W-1:0];
				default: ;
			endcase
		end
	end

	lcrts_readout u_readout (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.kind        (s_tuser),
		.data_level  (s_tdata[0]),
		.half_period (half_period_q),
		.tare_n      (tare_n_q),
		.weigh_n     (weigh_n_q),
		.stat        (rd)
	);

	lcrts_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// sign handling around the unsigned divider
	always_comb begin
		sum_mag  = rd.sum[lcrts_pkg::SUM_W-1] ? lcrts_pkg::SUM_W'(-rd.sum)
			: lcrts_pkg::SUM_W'(rd.sum);
		avg      = rd.sum[lcrts_pkg::SUM_W-1] ? -signed'(div_quot[SB-1:0])
			: signed'(div_quot[SB-1:0]);
		diff     = (SB+1)'(avg) - (SB+1)'(offset_q);
		diff_mag = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
		weight   = diff_neg_q ? -signed'(div_quot) : signed'(div_quot);
		cpk_eff  = (cpk_q == '0) ? lcrts_pkg::CPK_W'(1) : cpk_q;
		out_free = !m_tvalid_q || m_tready;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			lcrts_pkg::ST_IDLE:  if (accept) st_d = lcrts_pkg::ST_EVAL;
			lcrts_pkg::ST_EVAL:  st_d = rd.done ? lcrts_pkg::ST_AVG : lcrts_pkg::ST_OUT;
			lcrts_pkg::ST_AVG: begin
				if (div_stat.done)
					st_d = rd.is_tare ? lcrts_pkg::ST_OUT : lcrts_pkg::ST_WEIGH;
			end
			lcrts_pkg::ST_WEIGH: if (div_stat.done) st_d = lcrts_pkg::ST_OUT;
			lcrts_pkg::ST_OUT:   if (out_free) st_d = lcrts_pkg::ST_IDLE;
			default:             st_d = lcrts_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = lcrts_pkg::DIV_W'(sum_mag);
		div_divisor  = lcrts_pkg::DVSR_W'(rd.run_len);
		case (st_q)
			lcrts_pkg::ST_IDLE: s_tready = 1'b1;
			lcrts_pkg::ST_EVAL: div_start = rd.done;
			lcrts_pkg::ST_AVG: begin
				div_start    = div_stat.done && !rd.is_tare;
				div_dividend = lcrts_pkg::DIV_W'({diff_mag[SB-1:0],
					{lcrts_pkg::FRAC_BITS{1'b0}}});
				div_divisor  = cpk_eff;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= lcrts_pkg::ST_IDLE;
			offset_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == lcrts_pkg::ST_AVG && div_stat.done && rd.is_tare)
				offset_q <= avg;
			if (st_q == lcrts_pkg::ST_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// result staging and output register
	always_ff @(posedge clk) begin
		case (st_q)
			lcrts_pkg::ST_EVAL: begin
				res_valid_q  <= rd.done;
				res_tare_q   <= rd.done && rd.is_tare;
				res_avg_q    <= '0;
				res_weight_q <= '0;
			end
			lcrts_pkg::ST_AVG: begin
				if (div_stat.done) begin
					res_avg_q  <= avg;
					diff_neg_q <= diff[SB];
				end
			end
			lcrts_pkg::ST_WEIGH: begin
				if (div_stat.done) res_weight_q <= weight;
			end
			lcrts_pkg::ST_OUT: begin
				if (out_free) begin
					m_clock_q  <= rd.clock_level;
					m_busy_q   <= rd.busy;
					m_valid_q  <= res_valid_q;
					m_tare_q   <= res_tare_q;
					m_avg_q    <= res_avg_q;
					m_weight_q <= res_weight_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, m_weight_q, m_avg_q, m_busy_q, m_clock_q};
	assign m_tuser  = {m_tare_q, m_valid_q};

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == lcrts_pkg::ST_EVAL))
		else $error("accepted beat not taken into evaluation");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_valid_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> !m_tdata[1])
		else $error("finished run reported while still busy");

endmodule

`default_nettype wire

// ===== tb/load_cell_readout_tare_scale_tb.sv =====
// Self-checking testbench for the load-cell readout: driver, monitor and readout predictor.
`timescale 1ns / 100ps

module load_cell_readout_tare_scale_tb;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [1:0] kind;
		logic       level;
	} adc_beat_t;

	typedef struct packed {
		logic        clk_lvl;
		logic        busy;
		logic        done;
		logic        is_tare;
		logic [23:0] avg;
		logic [40:0] weight;
	} readout_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;
	logic [1:0]                    s_tuser = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [71:0]                   m_tdata;
	logic [1:0]                    m_tuser;
	logic                          cfg_we = 1'b0;
	logic [lcrts_pkg::IDX_W-1:0]   cfg_index = '0;
	logic [lcrts_pkg::CFG_W-1:0]   cfg_data = '0;

	load_cell_readout_tare_scale uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register shadows
	bit [7:0]  cfg_hp      = lcrts_pkg::HP_RESET;
	bit [5:0]  cfg_tare_n  = lcrts_pkg::TARE_N_RESET;
	bit [5:0]  cfg_weigh_n = lcrts_pkg::WEIGH_N_RESET;
	bit [23:0] cfg_cpk     = lcrts_pkg::CPK_RESET;

	// readout state mirror
	lcrts_pkg::rd_phase_t rd_phase = lcrts_pkg::RD_IDLE;
	int          rd_half_cnt = 0;
	int          rd_pulse = 0;
	logic [23:0] rd_shift = '0;
	int          rd_samples = 0;
	longint      rd_sum = 0;
	longint      rd_offset = 0;
	bit          rd_tare = 1'b0;
	logic        rd_clk = 1'b0;

	adc_beat_t   beat_q[$];
	readout_t    readout_q[$];
	adc_beat_t   on_bus;
	readout_t    next_readout;
	readout_t    got, want;
	int          n_queued = 0;
	int          bad_readouts = 0;
	int unsigned cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	bit          send_pause = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_taken = 1'b0;
	int          recv_hold = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic readout_step(input adc_beat_t it, output readout_t r);
		int     hp;
		longint n, avg, wt, cpk;
		r = '0;
		hp = (cfg_hp == 0) ? 1 : int'(cfg_hp);
		if (rd_phase == lcrts_pkg::RD_IDLE) begin
			if (it.kind == lcrts_pkg::KIND_TARE || it.kind == lcrts_pkg::KIND_WEIGH) begin
				rd_tare = (it.kind == lcrts_pkg::KIND_TARE);
				rd_samples = 0;
				rd_sum = 0;
				rd_pulse = 0;
				rd_half_cnt = 0;
				rd_shift = '0;
				rd_clk = 1'b0;
				rd_phase = lcrts_pkg::RD_WAIT;
			end
		end else if (it.kind == lcrts_pkg::KIND_TICK) begin
			case (rd_phase)
				lcrts_pkg::RD_WAIT: begin
					if (!it.level) begin
						rd_clk = 1'b1;
						rd_half_cnt = 0;
						rd_pulse = 0;
						rd_shift = '0;
						rd_phase = lcrts_pkg::RD_HIGH;
					end
				end
				lcrts_pkg::RD_HIGH: begin
					rd_half_cnt++;
					if (rd_half_cnt >= hp) begin
						if (rd_pulse < lcrts_pkg::SAMPLE_BITS)
							rd_shift = {rd_shift[22:0], it.level};
						rd_clk = 1'b0;
						rd_half_cnt = 0;
						rd_phase = lcrts_pkg::RD_LOW;
					end
				end
				default: begin
					rd_half_cnt++;
					if (rd_half_cnt >= hp) begin
						rd_half_cnt = 0;
						if (rd_pulse >= lcrts_pkg::SAMPLE_BITS) begin
							n = rd_tare ? longint'(cfg_tare_n) : longint'(cfg_weigh_n);
							if (n == 0)
								n = 1;
							rd_sum = rd_sum + longint'($signed(rd_shift));
							rd_samples++;
							rd_pulse = 0;
							if (rd_samples >= n) begin
								avg = rd_sum / n;
								r.done = 1'b1;
								r.is_tare = rd_tare;
								r.avg = avg[23:0];
								if (rd_tare) begin
									rd_offset = avg;
								end else begin
									cpk = (cfg_cpk == 0) ? 1 : longint'(cfg_cpk);
									wt = ((avg - rd_offset) *
										(longint'(1) << lcrts_pkg::FRAC_BITS)) / cpk;
									r.weight = wt[40:0];
								end
								rd_phase = lcrts_pkg::RD_IDLE;
							end else begin
								rd_phase = lcrts_pkg::RD_WAIT;
							end
						end else begin
							rd_pulse++;
							rd_clk = 1'b1;
							rd_phase = lcrts_pkg::RD_HIGH;
						end
					end
				end
			endcase
		end
		r.clk_lvl = rd_clk;
		r.busy = (rd_phase != lcrts_pkg::RD_IDLE);
	endtask

	// driver: predict on acceptance, then offer the next beat
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				readout_step(on_bus, next_readout);
				readout_q.push_back(next_readout);
			end
			if (!s_tvalid || s_tready) begin
				if (beat_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle) begin
					on_bus = beat_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, on_bus.level};
					s_tuser <= on_bus.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure, with one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			recv_hold <= 400;
			m_tready <= 1'b0;
		end else if (recv_hold != 0) begin
			recv_hold <= recv_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[1], m_tuser[0], m_tuser[1],
				m_tdata[25:2], m_tdata[66:26]};
			if (readout_q.size() == 0) begin
				bad_readouts++;
				if (bad_readouts <= 10)
					$display("unexpected output beat: clk=%0b busy=%0b done=%0b %s%0b %s%0d %s%0d",
						got.clk_lvl, got.busy, got.done, "tare=", got.is_tare,
						"avg=", $signed(got.avg), "wt=", $signed(got.weight));
			end else begin
				want = readout_q.pop_front();
				if (got !== want) begin
					bad_readouts++;
					if (bad_readouts <= 10) begin
						$display("mismatch at %0t: expected clk=%0b busy=%0b done=%0b %s%0b %s%0d %s%0d",
							$realtime, want.clk_lvl, want.busy, want.done,
							"tare=", want.is_tare, "avg=", $signed(want.avg),
							"wt=", $signed(want.weight));
						$display("                 actual clk=%0b busy=%0b done=%0b %s%0b %s%0d %s%0d",
							got.clk_lvl, got.busy, got.done,
							"tare=", got.is_tare, "avg=", $signed(got.avg),
							"wt=", $signed(got.weight));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[load_cell_readout_tare_scale] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [lcrts_pkg::IDX_W-1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lcrts_pkg::REG_HALF_PERIOD: cfg_hp = val[7:0];
			lcrts_pkg::REG_TARE_N:      cfg_tare_n = val[5:0];
			lcrts_pkg::REG_WEIGH_N:     cfg_weigh_n = val[5:0];
			default:                    cfg_cpk = val;
		endcase
	endtask

	task automatic add_beat(input logic [1:0] kind, input logic level);
		adc_beat_t b;
		b.kind = kind;
		b.level = level;
		beat_q.push_back(b);
		n_queued++;
	endtask

	// inside a run: ignored commands and reserved kinds that must not advance time
	task automatic add_noise();
		int sel;
		if ($urandom_range(99) < 4) begin
			sel = $urandom_range(0, 2);
			add_beat((sel == 0) ? KIND_NONE : (sel == 1) ? lcrts_pkg::KIND_TARE :
				lcrts_pkg::KIND_WEIGH, 1'($urandom_range(1)));
		end
	endtask

	// while idle: ticks and reserved kinds only, never a start
	task automatic add_idle_noise(input int count);
		int i;
		for (i = 0; i < count; i++)
			add_beat(($urandom_range(3) == 0) ? KIND_NONE : lcrts_pkg::KIND_TICK,
				1'($urandom_range(1)));
	endtask

	task automatic add_conversion(input logic [23:0] word, input int nwait);
		int hp, p, t;
		hp = (cfg_hp == 0) ? 1 : int'(cfg_hp);
		for (t = 0; t < nwait; t++) begin
			add_noise();
			add_beat(lcrts_pkg::KIND_TICK, 1'b1);
		end
		add_beat(lcrts_pkg::KIND_TICK, 1'b0);
		for (p = 0; p <= lcrts_pkg::SAMPLE_BITS; p++) begin
			for (t = 1; t <= hp; t++) begin
				add_noise();
				add_beat(lcrts_pkg::KIND_TICK, (t == hp && p < lcrts_pkg::SAMPLE_BITS) ?
					word[lcrts_pkg::SAMPLE_BITS-1-p] : logic'($urandom_range(1)));
			end
			for (t = 1; t <= hp; t++) begin
				add_noise();
				add_beat(lcrts_pkg::KIND_TICK, 1'($urandom_range(1)));
			end
		end
	endtask

	function automatic logic [23:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'hFFFFFF;
			3: return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] pick_cpk();
		case ($urandom_range(0, 4))
			0: return 24'd1;
			1: return 24'hFFFFFF;
			2: return 24'd91760;
			3: return 24'($urandom_range(0, 1000));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_run(input bit tare, input bit fixed, input logic [23:0] word);
		int n, i, nwait;
		n = tare ? int'(cfg_tare_n) : int'(cfg_weigh_n);
		if (n == 0)
			n = 1;
		add_beat(tare ? lcrts_pkg::KIND_TARE : lcrts_pkg::KIND_WEIGH, 1'($urandom_range(1)));
		for (i = 0; i < n; i++) begin
			nwait = ($urandom_range(9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			add_conversion(fixed ? word : pick_word(), nwait);
		end
	endtask

	// drain everything in flight, then allow for the divider tail
	task automatic settle();
		while (beat_q.size() != 0 || s_tvalid || readout_q.size() != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_phase(input int sidle, input int ridle, input int budget,
			input bit pressure);
		int first;
		send_idle <= sidle;
		recv_idle <= ridle;
		first = n_queued;
		while (n_queued - first < budget) begin
			write_reg(lcrts_pkg::REG_HALF_PERIOD, ($urandom_range(9) < 7) ?
				24'($urandom_range(0, 1)) : 24'($urandom_range(2, 3)));
			write_reg(lcrts_pkg::REG_TARE_N, 24'($urandom_range(0, 3)));
			write_reg(lcrts_pkg::REG_WEIGH_N, 24'($urandom_range(0, 3)));
			write_reg(lcrts_pkg::REG_COUNTS_KG, pick_cpk());
			repeat ($urandom_range(1, 2)) begin
				add_idle_noise($urandom_range(0, 4));
				add_run($urandom_range(9) < 3, 1'b0, '0);
			end
			add_idle_noise($urandom_range(0, 4));
			if (pressure) begin
				pressure = 1'b0;
				hold_req <= 1'b1;
				repeat (600) @(posedge clk);
				send_pause <= 1'b1;
				@(negedge clk);
				while (s_tvalid || readout_q.size() != 0)
					@(negedge clk);
				@(posedge clk);
				send_pause <= 1'b0;
			end
			settle();
		end
	endtask

	initial begin
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: one weigh run against a zero offset
		send_idle <= 32;
		recv_idle <= 87;
		add_idle_noise(5);
		add_run(1'b0, 1'b0, '0);
		settle();

		// zero-valued registers and extreme readings
		write_reg(lcrts_pkg::REG_HALF_PERIOD, 24'd0);
		write_reg(lcrts_pkg::REG_TARE_N, 24'd0);
		write_reg(lcrts_pkg::REG_WEIGH_N, 24'd1);
		write_reg(lcrts_pkg::REG_COUNTS_KG, 24'd0);
		add_beat(KIND_NONE, 1'b1);
		add_beat(lcrts_pkg::KIND_TICK, 1'b0);
		add_beat(lcrts_pkg::KIND_TICK, 1'b1);
		add_beat(KIND_NONE, 1'b0);
		add_beat(lcrts_pkg::KIND_TARE, 1'b1);
		add_beat(lcrts_pkg::KIND_WEIGH, 1'b0);
		add_beat(lcrts_pkg::KIND_TARE, 1'b0);
		add_beat(KIND_NONE, 1'b1);
		add_conversion(24'h800000, 3);
		add_run(1'b0, 1'b1, 24'h7FFFFF);
		add_run(1'b1, 1'b1, 24'h7FFFFF);
		add_run(1'b0, 1'b1, 24'h800000);
		add_run(1'b1, 1'b1, 24'h000000);
		add_run(1'b0, 1'b1, 24'hFFFFFF);
		settle();

		random_phase(32, 87, 120, 1'b0);
		random_phase(87, 32, 120, 1'b0);
		random_phase(0, 0, 120, 1'b1);

		// widest half period over one full high half, then finish at the shortest
		write_reg(lcrts_pkg::REG_HALF_PERIOD, 24'd255);
		write_reg(lcrts_pkg::REG_WEIGH_N, 24'd1);
		write_reg(lcrts_pkg::REG_COUNTS_KG, 24'hFFFFFF);
		add_beat(lcrts_pkg::KIND_WEIGH, 1'b0);
		add_beat(lcrts_pkg::KIND_TICK, 1'b0);
		for (i = 0; i < 265; i++)
			add_beat(lcrts_pkg::KIND_TICK, 1'($urandom_range(1)));
		settle();
		write_reg(lcrts_pkg::REG_HALF_PERIOD, 24'd1);
		for (i = 0; i < 52; i++)
			add_beat(lcrts_pkg::KIND_TICK, 1'($urandom_range(1)));
		settle();

		if (bad_readouts == 0) begin
			$display("[load_cell_readout_tare_scale] OK");
		end else begin
			$display("[load_cell_readout_tare_scale] ERROR");
		end
		$finish;
	end

endmodule
